### design/assert_macros.svh
// Assertion shorthands for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check, ignored while reset is held.
`define VRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check in the cycle after the trigger, ignored while reset is held.
`define VRP_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

### design/vrp_pkg.sv
package vrp_pkg;

  localparam int SCREEN_SIZE = 128;
  localparam int SCALE_K     = SCREEN_SIZE / 4;
  localparam int SCALE_MUL   = 6 * SCALE_K;
  localparam int DEN_MUL     = SCREEN_SIZE + 1;

  localparam int IN_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 32;
  localparam int WIDE_W    = 48;
  localparam int SUM_W     = 49;
  localparam int RX_W      = 34;
  localparam int R_W       = 21;
  localparam int DEPTH_W   = 18;
  localparam int DEN_W     = 19;
  localparam int NUM_W     = 36;
  localparam int SCR_W     = 16;
  localparam int DIV_W     = 19;
  localparam int REM_W     = DIV_W + SCR_W;

  localparam int TRIG_SHIFT = 14;
  localparam int Q40_SHIFT  = 28;

  localparam int CAM_OFFSET  = 8192;
  localparam int NEAR_OFFSET = 12288;

  localparam int DEPTH_MAX = 2 ** (DEPTH_W - 1) - 1;
  localparam int DEPTH_MIN = -(2 ** (DEPTH_W - 1));
  localparam int SCR_MAX   = 2 ** (SCR_W - 1) - 1;
  localparam int SCR_MIN   = -(2 ** (SCR_W - 1));

  localparam logic [CFG_IDX_W-1:0] REG_COS_THETA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIN_THETA = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COS_PHI   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SIN_PHI   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OBJ_DIST  = CFG_IDX_W'(4);

  localparam logic signed [CFG_W-1:0] RST_COS      = CFG_W'(16384);
  localparam logic signed [CFG_W-1:0] RST_SIN      = CFG_W'(0);
  localparam logic signed [CFG_W-1:0] RST_OBJ_DIST = CFG_W'(6144);

  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    logic                      behind;
    logic                      last;
  } meta_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [SCR_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } div_lane_t;

  // One restoring step: try to take d << b out of the remainder.
  function automatic div_lane_t div_step(div_lane_t l, logic [DIV_W-1:0] d, int unsigned b);
    logic [REM_W:0] dsh;
    logic [REM_W:0] diff;
    div_lane_t      n;
    dsh  = (REM_W + 1)'(d) << b;
    diff = {1'b0, l.rem} - dsh;
    n    = l;
    if (!diff[REM_W]) begin
      n.rem = diff[REM_W-1:0];
      n.quo = l.quo | (SCR_W'(1) << b);
    end
    return n;
  endfunction

  // Apply the sign and clamp to the screen range.
  function automatic logic signed [SCR_W-1:0] sat_quot(div_lane_t l);
    logic signed [SCR_W-1:0] res;
    if (l.ovf) begin
      res = l.neg ? SCR_W'(SCR_MIN) : SCR_W'(SCR_MAX);
    end else if (l.neg) begin
      res = (l.quo > SCR_W'(2 ** (SCR_W - 1))) ? SCR_W'(SCR_MIN) : SCR_W'(-l.quo);
    end else begin
      res = l.quo[SCR_W-1] ? SCR_W'(SCR_MAX) : l.quo;
    end
    return res;
  endfunction

endpackage

### design/vertex_rotate_project.sv
// The pipeline takes one word per cycle while not stalled; 8 arithmetic stages feed a
// 16-stage restoring divider (one quotient bit per stage), so the pipeline is 25
// registers deep. Back-pressure freezes the whole pipeline only while the output
// register holds a word that is stalled. Reset clears all valid bits and loads the
// register defaults.
module vertex_rotate_project import vrp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [IN_W-1:0]    in_vertex_x,
  input  logic signed [IN_W-1:0]    in_vertex_y,
  input  logic signed [IN_W-1:0]    in_vertex_z,
  input  logic                      in_last_vertex,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SCR_W-1:0]   out_screen_x,
  output logic signed [SCR_W-1:0]   out_screen_y,
  output logic signed [DEPTH_W-1:0] out_view_depth,
  output logic                      out_behind_camera,
  output logic                      out_last_out,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

`include "assert_macros.svh"

  logic signed [CFG_W-1:0] cos_theta_r, sin_theta_r, cos_phi_r, sin_phi_r, obj_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_theta_r <= RST_COS;
      sin_theta_r <= RST_SIN;
      cos_phi_r   <= RST_COS;
      sin_phi_r   <= RST_SIN;
      obj_dist_r  <= RST_OBJ_DIST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COS_THETA: cos_theta_r <= cfg_data;
        REG_SIN_THETA: sin_theta_r <= cfg_data;
        REG_COS_PHI:   cos_phi_r   <= cfg_data;
        REG_SIN_PHI:   sin_phi_r   <= cfg_data;
        REG_OBJ_DIST:  obj_dist_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic       en;
  logic       out_valid_r;
  logic [7:1] pv_r;
  logic       dv_r [0:SCR_W];

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage 1: trig products and coordinate products.
  logic signed [PROD_W-1:0] ctcp1_r, ctsp1_r, stcp1_r, stsp1_r;
  logic signed [PROD_W-1:0] ctx1_r, stz1_r, cpy1_r, spy1_r;
  logic signed [IN_W-1:0]   x1_r, z1_r;
  logic                     last1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ctcp1_r <= PROD_W'(cos_theta_r) * PROD_W'(cos_phi_r);
      ctsp1_r <= PROD_W'(cos_theta_r) * PROD_W'(sin_phi_r);
      stcp1_r <= PROD_W'(sin_theta_r) * PROD_W'(cos_phi_r);
      stsp1_r <= PROD_W'(sin_theta_r) * PROD_W'(sin_phi_r);
      ctx1_r  <= PROD_W'(cos_theta_r) * PROD_W'(in_vertex_x);
      stz1_r  <= PROD_W'(sin_theta_r) * PROD_W'(in_vertex_z);
      cpy1_r  <= PROD_W'(cos_phi_r) * PROD_W'(in_vertex_y);
      spy1_r  <= PROD_W'(sin_phi_r) * PROD_W'(in_vertex_y);
      x1_r    <= in_vertex_x;
      z1_r    <= in_vertex_z;
      last1_r <= in_last_vertex;
    end
  end

  // Stage 2: second-order products, x sum.
  logic signed [WIDE_W-1:0] ctcpz2_r, stcpx2_r, stspx2_r, ctspz2_r;
  logic signed [RX_W-1:0]   rxs2_r;
  logic signed [PROD_W-1:0] cpy2_r, spy2_r;
  logic                     last2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ctcpz2_r <= WIDE_W'(ctcp1_r) * WIDE_W'(z1_r);
      stcpx2_r <= WIDE_W'(stcp1_r) * WIDE_W'(x1_r);
      stspx2_r <= WIDE_W'(stsp1_r) * WIDE_W'(x1_r);
      ctspz2_r <= WIDE_W'(ctsp1_r) * WIDE_W'(z1_r);
      rxs2_r   <= RX_W'(ctx1_r) + RX_W'(stz1_r);
      cpy2_r   <= cpy1_r;
      spy2_r   <= spy1_r;
      last2_r  <= last1_r;
    end
  end

  // Stage 3: Q40 sums rounded to Q12.
  logic signed [SUM_W-1:0] ry_sum, rz_sum;
  logic signed [RX_W-1:0]  rx_sum;
  logic signed [R_W-1:0]   rx3_r, ry3_r, rz3_r;
  logic                    last3_r;

  always_comb begin
    ry_sum = SUM_W'(ctspz2_r) - SUM_W'(stspx2_r) + (SUM_W'(cpy2_r) <<< TRIG_SHIFT)
           + SUM_W'(2 ** (Q40_SHIFT - 1));
    rz_sum = SUM_W'(ctcpz2_r) - SUM_W'(stcpx2_r) - (SUM_W'(spy2_r) <<< TRIG_SHIFT)
           + SUM_W'(2 ** (Q40_SHIFT - 1));
    rx_sum = rxs2_r + RX_W'(2 ** (TRIG_SHIFT - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx3_r   <= R_W'(rx_sum >>> TRIG_SHIFT);
      ry3_r   <= ry_sum[Q40_SHIFT +: R_W];
      rz3_r   <= rz_sum[Q40_SHIFT +: R_W];
      last3_r <= last2_r;
    end
  end

  // Stage 4: camera offset and depth clamp.
  logic signed [R_W:0]       depth_raw;
  logic signed [DEPTH_W-1:0] depth_nxt;
  logic signed [DEPTH_W-1:0] depth4_r;
  logic signed [R_W-1:0]     rx4_r, ry4_r;
  logic                      last4_r;

  always_comb begin
    depth_raw = (R_W + 1)'(rz3_r) + (R_W + 1)'(CAM_OFFSET);
    if (depth_raw > (R_W + 1)'(DEPTH_MAX)) begin
      depth_nxt = DEPTH_W'(DEPTH_MAX);
    end else if (depth_raw < (R_W + 1)'(DEPTH_MIN)) begin
      depth_nxt = DEPTH_W'(DEPTH_MIN);
    end else begin
      depth_nxt = depth_raw[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth4_r <= depth_nxt;
      rx4_r    <= rx3_r;
      ry4_r    <= ry3_r;
      last4_r  <= last3_r;
    end
  end

  // Stage 5: perspective denominator.
  logic signed [DEN_W-1:0] den_nxt;
  logic signed [DEN_W-1:0] den5_r;
  logic signed [R_W-1:0]   rx5_r, ry5_r;
  meta_t                   m5_r;

  assign den_nxt = DEN_W'(depth4_r) + DEN_W'(NEAR_OFFSET) + DEN_W'(obj_dist_r);

  always_ff @(posedge clk) begin
    if (en) begin
      den5_r      <= den_nxt;
      rx5_r       <= rx4_r;
      ry5_r       <= ry4_r;
      m5_r.depth  <= depth4_r;
      m5_r.behind <= den_nxt[DEN_W-1] || (den_nxt == '0);
      m5_r.last   <= last4_r;
    end
  end

  // Stage 6: numerators and doubled denominator.
  logic signed [NUM_W-1:0] numx6_r, numy6_r;
  logic [DIV_W-1:0]        d6_r;
  meta_t                   m6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      numx6_r <= NUM_W'(den5_r) * NUM_W'(DEN_MUL) + NUM_W'(rx5_r) * NUM_W'(SCALE_MUL);
      numy6_r <= NUM_W'(den5_r) * NUM_W'(DEN_MUL) + NUM_W'(ry5_r) * NUM_W'(SCALE_MUL);
      d6_r    <= {den5_r[DIV_W-2:0], 1'b0};
      m6_r    <= m5_r;
    end
  end

  // Stage 7: magnitudes.
  logic [NUM_W-1:0] ax7_r, ay7_r;
  logic             nx7_r, ny7_r;
  logic [DIV_W-1:0] d7_r;
  meta_t            m7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ax7_r <= numx6_r[NUM_W-1] ? NUM_W'(-numx6_r) : NUM_W'(numx6_r);
      ay7_r <= numy6_r[NUM_W-1] ? NUM_W'(-numy6_r) : NUM_W'(numy6_r);
      nx7_r <= numx6_r[NUM_W-1];
      ny7_r <= numy6_r[NUM_W-1];
      d7_r  <= d6_r;
      m7_r  <= m6_r;
    end
  end

  // Stage 8 is the divider's entry: overflow check and initial remainder.
  div_lane_t        dx_r [0:SCR_W];
  div_lane_t        dy_r [0:SCR_W];
  logic [DIV_W-1:0] dd_r [0:SCR_W];
  meta_t            dm_r [0:SCR_W];
  logic [NUM_W-1:0] dlim;

  assign dlim = NUM_W'({d7_r, SCR_W'(0)});

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r[0].rem <= ax7_r[REM_W-1:0];
      dx_r[0].quo <= '0;
      dx_r[0].neg <= nx7_r;
      dx_r[0].ovf <= ax7_r >= dlim;
      dy_r[0].rem <= ay7_r[REM_W-1:0];
      dy_r[0].quo <= '0;
      dy_r[0].neg <= ny7_r;
      dy_r[0].ovf <= ay7_r >= dlim;
      dd_r[0]     <= d7_r;
      dm_r[0]     <= m7_r;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < SCR_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dx_r[k+1] <= div_step(dx_r[k], dd_r[k], SCR_W - 1 - k);
        dy_r[k+1] <= div_step(dy_r[k], dd_r[k], SCR_W - 1 - k);
        dd_r[k+1] <= dd_r[k];
        dm_r[k+1] <= dm_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end
  end

  // Output register.
  logic signed [SCR_W-1:0]   sx_r, sy_r;
  logic signed [DEPTH_W-1:0] depth_r;
  logic                      behind_r, last_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r     <= dm_r[SCR_W].behind ? '0 : sat_quot(dx_r[SCR_W]);
      sy_r     <= dm_r[SCR_W].behind ? '0 : sat_quot(dy_r[SCR_W]);
      depth_r  <= dm_r[SCR_W].depth;
      behind_r <= dm_r[SCR_W].behind;
      last_r   <= dm_r[SCR_W].last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      dv_r[0]     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pv_r        <= {pv_r[6:1], in_valid};
      dv_r[0]     <= pv_r[7];
      out_valid_r <= dv_r[SCR_W];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_screen_x      = sx_r;
  assign out_screen_y      = sy_r;
  assign out_view_depth    = depth_r;
  assign out_behind_camera = behind_r;
  assign out_last_out      = last_r;

  `VRP_ASSERT(a_rem_below_div, !(dv_r[SCR_W] && !dm_r[SCR_W].behind && !dx_r[SCR_W].ovf) || (dx_r[SCR_W].rem < REM_W'(dd_r[SCR_W])), "final remainder not below divisor")
  `VRP_ASSERT(a_behind_zero, !(out_valid && out_behind_camera) || (out_screen_x == '0 && out_screen_y == '0), "behind-camera word with non-zero screen position")
  `VRP_ASSERT_NEXT(a_out_follows, en, out_valid == $past(dv_r[SCR_W]), "output valid lost its pipeline source")
  `VRP_ASSERT_NEXT(a_freeze, !en, $stable(pv_r) && out_valid, "pipeline moved while stalled")

endmodule
